// File: rtl/bfia_pkg.sv
package bfia_pkg;

  localparam int unsigned OP_W = 3;
  localparam int unsigned START_W = 16;
  localparam int unsigned LEN_W = 17;
  localparam int unsigned LOC_W = 16;
  localparam int unsigned REGION_W = 2;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC = 3'd0,
    OP_FREE  = 3'd1,
    OP_QUERY = 3'd2,
    OP_GROW  = 3'd3,
    OP_CLEAR = 3'd4
  } op_t;

  typedef enum logic [REGION_W-1:0] {
    REGION_FREE    = 2'd0,
    REGION_PARTIAL = 2'd1,
    REGION_USED    = 2'd2
  } region_t;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_APPLY = 3'b100
  } state_t;

  typedef struct packed {
    logic start;
    logic eval;
  } scan_ctl_t;

  typedef struct packed {
    logic wr_begin;
    logic wr_end;
    logic set_valid;
    logic clr_valid;
    logic clr_all;
  } tbl_wr_t;

endpackage

// File: rtl/bfia_in_if.sv
interface bfia_in_if;
  logic                           valid;
  logic                           ready;
  logic [bfia_pkg::OP_W-1:0]      operation;
  logic [bfia_pkg::START_W-1:0]   start_req;
  logic [bfia_pkg::LEN_W-1:0]     length;

  modport source (output valid, output operation, output start_req, output length,
                  input ready);
  modport sink (input valid, input operation, input start_req, input length,
                output ready);
endinterface

// File: rtl/bfia_out_if.sv
interface bfia_out_if;
  logic                            valid;
  logic                            ready;
  logic                            ok;
  logic [bfia_pkg::LOC_W-1:0]      location;
  logic [bfia_pkg::REGION_W-1:0]   region_state;

  modport source (output valid, output ok, output location, output region_state,
                  input ready);
  modport sink (input valid, input ok, input location, input region_state,
                output ready);
endinterface

// File: rtl/best_fit_interval_allocator.sv
// Best-fit interval allocator over a pool of units kept as a table of free intervals.
// Requests arrive on in_bus as one beat holding operation, start_req and length.
// Each request produces exactly one beat on out_bus with ok, location and
// region_state.
// Every request makes one pass over the free-interval table through its single
// read port, one entry per cycle, with a two-stage evaluation pipeline behind it.
// The result is loaded into the output register in the update state after the
// table pass, and the next request can be accepted in the cycle after that, so
// requests are taken one at a time.
// A new request is accepted while the previous result still waits in the output
// register; if the receiver stalls, the following request is held just before its
// table update until that result has been taken.
// After reset the pool is empty, no interval is free and no result is pending.
module best_fit_interval_allocator #(
  parameter int unsigned MAX_FREE_INTERVALS = 64,
  parameter int unsigned POOL_ADDRESS_BITS  = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  bfia_in_if.sink    in_bus,
  bfia_out_if.source out_bus
);

  localparam int unsigned N     = MAX_FREE_INTERVALS;
  localparam int unsigned IW    = (N > 1) ? $clog2(N) : 1;
  localparam int unsigned BW    = POOL_ADDRESS_BITS;
  localparam int unsigned EW    = POOL_ADDRESS_BITS + 1;
  localparam int unsigned CW    = (EW > bfia_pkg::LEN_W) ? EW : bfia_pkg::LEN_W;
  localparam int unsigned CNT_W = $clog2(N + 2);

  localparam logic [CNT_W-1:0] CNT_ISSUE_END = CNT_W'(N);
  localparam logic [CNT_W-1:0] CNT_LAST      = CNT_W'(N + 1);
  localparam logic [CW-1:0]    POOL_LIMIT    = CW'(1) << POOL_ADDRESS_BITS;

  bfia_pkg::state_t    state_r, state_nxt;
  logic [CNT_W-1:0]    cnt_r;
  logic                eval_r;
  logic [IW-1:0]       idx_r;
  bfia_pkg::op_t       op_r;
  logic [CW-1:0]       len_r, lo_r, hi_r;
  logic [EW-1:0]       pool_r, pool_nxt;
  logic                out_valid_r;
  logic                out_ok_r, ok_nxt;
  logic [bfia_pkg::LOC_W-1:0]    out_loc_r, loc_nxt;
  logic [bfia_pkg::REGION_W-1:0] out_region_r, region_nxt;

  logic                in_accept, issue, apply_go;
  bfia_pkg::scan_ctl_t ctl;
  bfia_pkg::tbl_wr_t   wr;
  logic [IW-1:0]       wr_addr, clr_addr;
  logic [BW-1:0]       wr_begin_data;
  logic [EW-1:0]       wr_end_data;
  logic [BW-1:0]       rd_begin;
  logic [EW-1:0]       rd_end;
  logic                rd_valid;

  logic                best_found, left_found, right_found, empty_found;
  logic [IW-1:0]       best_idx, left_idx, right_idx, empty_idx;
  logic [CW-1:0]       best_begin, best_end, left_begin, sum;
  logic [CW-1:0]       pool_ext, carve;
  logic                rel_en, rel_ok, range_ok;

  assign in_accept = in_bus.valid && in_bus.ready;
  assign in_bus.ready = (state_r == bfia_pkg::ST_IDLE);
  assign issue = (state_r == bfia_pkg::ST_SCAN) && (cnt_r < CNT_ISSUE_END);
  assign apply_go = (state_r == bfia_pkg::ST_APPLY) && (!out_valid_r || out_bus.ready);
  assign ctl.start = in_accept;
  assign ctl.eval = eval_r;
  assign pool_ext = CW'(pool_r);

  bfia_table #(.N(N), .IW(IW), .BW(BW), .EW(EW)) u_table (
    .clk          (clk),
    .rst_n        (rst_n),
    .rd_en        (issue),
    .rd_addr      (cnt_r[IW-1:0]),
    .rd_begin     (rd_begin),
    .rd_end       (rd_end),
    .rd_valid     (rd_valid),
    .wr           (wr),
    .wr_addr      (wr_addr),
    .wr_begin_data(wr_begin_data),
    .wr_end_data  (wr_end_data),
    .clr_addr     (clr_addr)
  );

  bfia_scan #(.IW(IW), .CW(CW)) u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .ent_idx    (idx_r),
    .ent_valid  (rd_valid),
    .ent_begin  (CW'(rd_begin)),
    .ent_end    (CW'(rd_end)),
    .lo         (lo_r),
    .hi         (hi_r),
    .len        (len_r),
    .best_found (best_found),
    .best_idx   (best_idx),
    .best_begin (best_begin),
    .best_end   (best_end),
    .left_found (left_found),
    .left_idx   (left_idx),
    .left_begin (left_begin),
    .right_found(right_found),
    .right_idx  (right_idx),
    .empty_found(empty_found),
    .empty_idx  (empty_idx),
    .sum        (sum)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bfia_pkg::ST_IDLE: begin
        if (in_accept) begin
          state_nxt = bfia_pkg::ST_SCAN;
        end
      end
      bfia_pkg::ST_SCAN: begin
        if (cnt_r == CNT_LAST) begin
          state_nxt = bfia_pkg::ST_APPLY;
        end
      end
      bfia_pkg::ST_APPLY: begin
        if (apply_go) begin
          state_nxt = bfia_pkg::ST_IDLE;
        end
      end
      default: state_nxt = bfia_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    carve      = best_begin + len_r;
    range_ok   = (len_r != '0) && (hi_r <= pool_ext);
    rel_en     = 1'b0;
    rel_ok     = 1'b0;
    wr         = '0;
    wr_addr    = '0;
    clr_addr   = '0;
    wr_begin_data = '0;
    wr_end_data   = '0;
    ok_nxt     = 1'b0;
    loc_nxt    = '0;
    region_nxt = bfia_pkg::REGION_FREE;
    pool_nxt   = pool_r;

    case (op_r)
      bfia_pkg::OP_ALLOC: begin
        if (best_found) begin
          ok_nxt        = 1'b1;
          loc_nxt       = bfia_pkg::LOC_W'(best_begin);
          wr.wr_begin   = 1'b1;
          wr_addr       = best_idx;
          wr_begin_data = BW'(carve);
          if (carve == best_end) begin
            wr.clr_valid = 1'b1;
            clr_addr     = best_idx;
          end
        end
      end
      bfia_pkg::OP_FREE: begin
        rel_en = range_ok && (sum == '0);
      end
      bfia_pkg::OP_QUERY: begin
        if (range_ok) begin
          ok_nxt = 1'b1;
          if (sum == len_r) begin
            region_nxt = bfia_pkg::REGION_FREE;
          end else if (sum == '0) begin
            region_nxt = bfia_pkg::REGION_USED;
          end else begin
            region_nxt = bfia_pkg::REGION_PARTIAL;
          end
        end
      end
      bfia_pkg::OP_GROW: begin
        if ((len_r >= pool_ext) && (len_r <= POOL_LIMIT)) begin
          if (len_r == pool_ext) begin
            ok_nxt = 1'b1;
          end else begin
            rel_en = 1'b1;
          end
        end
      end
      bfia_pkg::OP_CLEAR: begin
        if (len_r <= POOL_LIMIT) begin
          ok_nxt     = 1'b1;
          pool_nxt   = EW'(len_r);
          wr.clr_all = 1'b1;
          if (len_r != '0) begin
            wr.wr_begin  = 1'b1;
            wr.wr_end    = 1'b1;
            wr.set_valid = 1'b1;
            wr_end_data  = EW'(len_r);
          end
        end
      end
      default: ok_nxt = 1'b0;
    endcase

    if (rel_en) begin
      if (left_found && right_found) begin
        rel_ok        = 1'b1;
        wr.wr_begin   = 1'b1;
        wr_addr       = right_idx;
        wr_begin_data = BW'(left_begin);
        wr.clr_valid  = 1'b1;
        clr_addr      = left_idx;
      end else if (left_found) begin
        rel_ok      = 1'b1;
        wr.wr_end   = 1'b1;
        wr_addr     = left_idx;
        wr_end_data = EW'(hi_r);
      end else if (right_found) begin
        rel_ok        = 1'b1;
        wr.wr_begin   = 1'b1;
        wr_addr       = right_idx;
        wr_begin_data = BW'(lo_r);
      end else if (empty_found) begin
        rel_ok        = 1'b1;
        wr.wr_begin   = 1'b1;
        wr.wr_end     = 1'b1;
        wr.set_valid  = 1'b1;
        wr_addr       = empty_idx;
        wr_begin_data = BW'(lo_r);
        wr_end_data   = EW'(hi_r);
      end
      ok_nxt = rel_ok;
      if (rel_ok && (op_r == bfia_pkg::OP_GROW)) begin
        pool_nxt = EW'(len_r);
      end
    end

    if (!apply_go) begin
      wr = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bfia_pkg::ST_IDLE;
      cnt_r       <= '0;
      eval_r      <= 1'b0;
      pool_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      eval_r  <= issue;
      if (in_accept) begin
        cnt_r <= '0;
      end else if (state_r == bfia_pkg::ST_SCAN) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
      if (apply_go) begin
        pool_r      <= pool_nxt;
        out_valid_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= cnt_r[IW-1:0];
    if (in_accept) begin
      op_r  <= bfia_pkg::op_t'(in_bus.operation);
      len_r <= CW'(in_bus.length);
      if (in_bus.operation == bfia_pkg::OP_GROW) begin
        lo_r <= pool_ext;
        hi_r <= CW'(in_bus.length);
      end else begin
        lo_r <= CW'(in_bus.start_req);
        hi_r <= CW'(in_bus.start_req) + CW'(in_bus.length);
      end
    end
    if (apply_go) begin
      out_ok_r     <= ok_nxt;
      out_loc_r    <= loc_nxt;
      out_region_r <= region_nxt;
    end
  end

  assign out_bus.valid        = out_valid_r;
  assign out_bus.ok           = out_ok_r;
  assign out_bus.location     = out_loc_r;
  assign out_bus.region_state = out_region_r;

`ifndef SYNTHESIS
  a_accept_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> (state_r == bfia_pkg::ST_SCAN) && (cnt_r == '0))
    else $error("accepted beat did not start a table pass");

  a_cnt_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bfia_pkg::ST_SCAN) |-> (cnt_r <= CNT_LAST))
    else $error("scan counter ran past the table");

  a_pool_limit: assert property (@(posedge clk) disable iff (!rst_n)
    CW'(pool_r) <= POOL_LIMIT)
    else $error("pool size beyond the address space");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_bus.valid |-> out_bus.ok ||
      ((out_bus.location == '0) && (out_bus.region_state == bfia_pkg::REGION_FREE)))
    else $error("failed request carries a nonzero result");

  a_no_write_outside_apply: assert property (@(posedge clk) disable iff (!rst_n)
    (wr != '0) |-> apply_go)
    else $error("table written outside the update cycle");
`endif

endmodule

// File: rtl/bfia_table.sv
module bfia_table #(
  parameter int unsigned N  = 64,
  parameter int unsigned IW = 6,
  parameter int unsigned BW = 16,
  parameter int unsigned EW = 17
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              rd_en,
  input  logic [IW-1:0]     rd_addr,
  output logic [BW-1:0]     rd_begin,
  output logic [EW-1:0]     rd_end,
  output logic              rd_valid,
  input  bfia_pkg::tbl_wr_t wr,
  input  logic [IW-1:0]     wr_addr,
  input  logic [BW-1:0]     wr_begin_data,
  input  logic [EW-1:0]     wr_end_data,
  input  logic [IW-1:0]     clr_addr
);

  logic [BW-1:0] mem_begin [N];
  logic [EW-1:0] mem_end [N];
  logic [N-1:0]  valid_r;
  logic [N-1:0]  valid_nxt;
  logic [BW-1:0] rd_begin_r;
  logic [EW-1:0] rd_end_r;
  logic          rd_valid_r;

  always_comb begin
    valid_nxt = valid_r;
    if (wr.clr_all) begin
      valid_nxt = '0;
    end
    if (wr.clr_valid) begin
      valid_nxt[clr_addr] = 1'b0;
    end
    if (wr.set_valid) begin
      valid_nxt[wr_addr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      if (rd_en) begin
        rd_valid_r <= valid_r[rd_addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr.wr_begin) begin
      mem_begin[wr_addr] <= wr_begin_data;
    end
    if (wr.wr_end) begin
      mem_end[wr_addr] <= wr_end_data;
    end
    if (rd_en) begin
      rd_begin_r <= mem_begin[rd_addr];
      rd_end_r   <= mem_end[rd_addr];
    end
  end

  assign rd_begin = rd_begin_r;
  assign rd_end   = rd_end_r;
  assign rd_valid = rd_valid_r;

endmodule

// File: rtl/bfia_scan.sv
module bfia_scan #(
  parameter int unsigned IW = 6,
  parameter int unsigned CW = 17
) (
  input  logic                clk,
  input  logic                rst_n,
  input  bfia_pkg::scan_ctl_t ctl,
  input  logic [IW-1:0]       ent_idx,
  input  logic                ent_valid,
  input  logic [CW-1:0]       ent_begin,
  input  logic [CW-1:0]       ent_end,
  input  logic [CW-1:0]       lo,
  input  logic [CW-1:0]       hi,
  input  logic [CW-1:0]       len,
  output logic                best_found,
  output logic [IW-1:0]       best_idx,
  output logic [CW-1:0]       best_begin,
  output logic [CW-1:0]       best_end,
  output logic                left_found,
  output logic [IW-1:0]       left_idx,
  output logic [CW-1:0]       left_begin,
  output logic                right_found,
  output logic [IW-1:0]       right_idx,
  output logic                empty_found,
  output logic [IW-1:0]       empty_idx,
  output logic [CW-1:0]       sum
);

  logic          best_found_r, left_found_r, right_found_r, empty_found_r;
  logic [IW-1:0] best_idx_r, left_idx_r, right_idx_r, empty_idx_r;
  logic [CW-1:0] best_begin_r, best_end_r, best_len_r, left_begin_r;
  logic [CW-1:0] term_r, sum_r;
  logic          acc_r;
  logic [CW-1:0] ent_len, clip_lo, clip_hi, term;
  logic          fit, better;

  always_comb begin
    ent_len = ent_end - ent_begin;
    fit     = ent_valid && (len != '0) && (ent_len >= len);
    better  = !best_found_r || (ent_len < best_len_r) ||
              ((ent_len == best_len_r) && (ent_end < best_end_r));
    clip_lo = (ent_begin > lo) ? ent_begin : lo;
    clip_hi = (ent_end < hi) ? ent_end : hi;
    term    = (ent_valid && (clip_hi > clip_lo)) ? (clip_hi - clip_lo) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_found_r  <= 1'b0;
      left_found_r  <= 1'b0;
      right_found_r <= 1'b0;
      empty_found_r <= 1'b0;
      acc_r         <= 1'b0;
      sum_r         <= '0;
    end else if (ctl.start) begin
      best_found_r  <= 1'b0;
      left_found_r  <= 1'b0;
      right_found_r <= 1'b0;
      empty_found_r <= 1'b0;
      acc_r         <= 1'b0;
      sum_r         <= '0;
    end else begin
      acc_r <= ctl.eval;
      if (acc_r) begin
        sum_r <= sum_r + term_r;
      end
      if (ctl.eval) begin
        if (fit && better) begin
          best_found_r <= 1'b1;
        end
        if (ent_valid && (ent_end == lo) && !left_found_r) begin
          left_found_r <= 1'b1;
        end
        if (ent_valid && (ent_begin == hi) && !right_found_r) begin
          right_found_r <= 1'b1;
        end
        if (!ent_valid && !empty_found_r) begin
          empty_found_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.eval) begin
      term_r <= term;
      if (fit && better) begin
        best_idx_r   <= ent_idx;
        best_begin_r <= ent_begin;
        best_end_r   <= ent_end;
        best_len_r   <= ent_len;
      end
      if (ent_valid && (ent_end == lo) && !left_found_r) begin
        left_idx_r   <= ent_idx;
        left_begin_r <= ent_begin;
      end
      if (ent_valid && (ent_begin == hi) && !right_found_r) begin
        right_idx_r <= ent_idx;
      end
      if (!ent_valid && !empty_found_r) begin
        empty_idx_r <= ent_idx;
      end
    end
  end

  assign best_found  = best_found_r;
  assign best_idx    = best_idx_r;
  assign best_begin  = best_begin_r;
  assign best_end    = best_end_r;
  assign left_found  = left_found_r;
  assign left_idx    = left_idx_r;
  assign left_begin  = left_begin_r;
  assign right_found = right_found_r;
  assign right_idx   = right_idx_r;
  assign empty_found = empty_found_r;
  assign empty_idx   = empty_idx_r;
  assign sum         = sum_r;

endmodule

// File: tb/sv/bfia_checker.sv
module bfia_checker (
  input logic       clk,
  input logic       rst_n,
  bfia_in_if        in_bus,
  bfia_out_if       out_bus,
  output int        fail_count,
  output int        pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSLOT = 64;
  localparam logic [16:0] POOL_MAX = 17'h10000;

  typedef struct packed {
    logic                          ok;
    logic [bfia_pkg::LOC_W-1:0]    location;
    logic [bfia_pkg::REGION_W-1:0] region_state;
  } reply_t;

  logic [16:0] pool_size;
  logic [16:0] iv_lo [NSLOT];
  logic [16:0] iv_hi [NSLOT];
  logic        iv_on [NSLOT];
  reply_t      replies_due[$];

  function automatic logic [16:0] free_units_in(logic [16:0] s, logic [16:0] e);
    logic [16:0] sum;
    logic [16:0] b;
    logic [16:0] f;
    sum = 0;
    for (int i = 0; i < NSLOT; i++) begin
      if (iv_on[i]) begin
        b = (iv_lo[i] > s) ? iv_lo[i] : s;
        f = (iv_hi[i] < e) ? iv_hi[i] : e;
        if (f > b) sum += f - b;
      end
    end
    return sum;
  endfunction

  function automatic logic return_range(logic [16:0] s, logic [16:0] e);
    int l;
    int r;
    int spare;
    l = -1;
    r = -1;
    spare = -1;
    for (int i = 0; i < NSLOT; i++) begin
      if (iv_on[i] && iv_hi[i] == s && l < 0) l = i;
      if (iv_on[i] && iv_lo[i] == e && r < 0) r = i;
      if (!iv_on[i] && spare < 0) spare = i;
    end
    if (l >= 0 && r >= 0) begin
      iv_lo[r] = iv_lo[l];
      iv_on[l] = 1'b0;
    end else if (l >= 0) begin
      iv_hi[l] = e;
    end else if (r >= 0) begin
      iv_lo[r] = s;
    end else if (spare >= 0) begin
      iv_lo[spare] = s;
      iv_hi[spare] = e;
      iv_on[spare] = 1'b1;
    end else begin
      return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic reply_t apply_request(logic [2:0] op, logic [15:0] s, logic [16:0] len);
    reply_t rsp;
    logic [16:0] e;
    logic [16:0] f;
    logic [16:0] bl;
    int best;
    rsp = '0;
    e = {1'b0, s} + len;
    best = -1;
    bl = 0;
    case (op)
      bfia_pkg::OP_ALLOC: begin
        if (len != 0) begin
          for (int i = 0; i < NSLOT; i++) begin
            if (iv_on[i] && iv_hi[i] - iv_lo[i] >= len) begin
              if (best < 0 || iv_hi[i] - iv_lo[i] < bl ||
                  (iv_hi[i] - iv_lo[i] == bl && iv_hi[i] < iv_hi[best])) begin
                best = i;
                bl = iv_hi[i] - iv_lo[i];
              end
            end
          end
        end
        if (best >= 0) begin
          rsp.location = iv_lo[best][15:0];
          iv_lo[best] = iv_lo[best] + len;
          if (iv_lo[best] == iv_hi[best]) iv_on[best] = 1'b0;
          rsp.ok = 1'b1;
        end
      end
      bfia_pkg::OP_FREE: begin
        if (len != 0 && e <= pool_size && free_units_in(e - len, e) == 0)
          rsp.ok = return_range({1'b0, s}, e);
      end
      bfia_pkg::OP_QUERY: begin
        if (len != 0 && e <= pool_size) begin
          f = free_units_in({1'b0, s}, e);
          rsp.region_state = (f == len) ? bfia_pkg::REGION_FREE :
                             (f == 0) ? bfia_pkg::REGION_USED : bfia_pkg::REGION_PARTIAL;
          rsp.ok = 1'b1;
        end
      end
      bfia_pkg::OP_GROW: begin
        if (len >= pool_size && len <= POOL_MAX) begin
          if (len == pool_size) begin
            rsp.ok = 1'b1;
          end else if (return_range(pool_size, len)) begin
            pool_size = len;
            rsp.ok = 1'b1;
          end
        end
      end
      bfia_pkg::OP_CLEAR: begin
        if (len <= POOL_MAX) begin
          for (int i = 0; i < NSLOT; i++) iv_on[i] = 1'b0;
          pool_size = len;
          if (len > 0) begin
            iv_lo[0] = 0;
            iv_hi[0] = len;
            iv_on[0] = 1'b1;
          end
          rsp.ok = 1'b1;
        end
      end
      default: ;
    endcase
    return rsp;
  endfunction

  assign pending_count = replies_due.size();

  always @(posedge clk) begin
    reply_t want;
    int errs;
    errs = 0;
    if (!rst_n) begin
      pool_size = 0;
      for (int i = 0; i < NSLOT; i++) iv_on[i] = 1'b0;
      replies_due.delete();
      fail_count <= 0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (replies_due.size() == 0) begin
          $error("Result beat with no request outstanding");
          errs++;
        end else begin
          want = replies_due.pop_front();
          if (out_bus.ok !== want.ok) begin
            $error("ok expected %0d actual %0d", want.ok, out_bus.ok);
            errs++;
          end
          if (out_bus.location !== want.location) begin
            $error("location expected %0d actual %0d", want.location, out_bus.location);
            errs++;
          end
          if (out_bus.region_state !== want.region_state) begin
            $error("region_state expected %0d actual %0d", want.region_state,
                   out_bus.region_state);
            errs++;
          end
        end
      end
      if (in_bus.valid && in_bus.ready)
        replies_due.push_back(apply_request(in_bus.operation, in_bus.start_req, in_bus.length));
      fail_count <= fail_count + errs;
    end
  end
endmodule

// File: tb/sv/tb_best_fit_interval_allocator.sv
module tb_best_fit_interval_allocator;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 1500000;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending_count;
  int   cycle_count;
  logic long_hold;
  logic [16:0] pool_now;
  logic [15:0] alloc_starts[$];
  logic [16:0] alloc_lens[$];

  bfia_in_if  in_bus();
  bfia_out_if out_bus();

  best_fit_interval_allocator u_dut (
    .clk(clk), .rst_n(rst_n), .in_bus(in_bus.sink), .out_bus(out_bus.source)
  );

  bfia_checker u_checker (
    .clk(clk), .rst_n(rst_n), .in_bus(in_bus), .out_bus(out_bus),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      cycle_count <= 0;
    end else begin
      cycle_count <= cycle_count + 1;
    end
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else if (long_hold) begin
      out_bus.ready <= 1'b0;
    end else begin
      case (cycle_count[11:9])
        3'd0: out_bus.ready <= 1'b1;
        3'd1: out_bus.ready <= ($urandom_range(0, 3) != 0);
        3'd2: out_bus.ready <= ($urandom_range(0, 1) != 0);
        default: out_bus.ready <= ($urandom_range(0, 9) < 8) ^ cycle_count[4] & cycle_count[6];
      endcase
    end
  end

  task automatic send_beat(logic [2:0] op, logic [15:0] s, logic [16:0] len);
    in_bus.valid     <= 1'b1;
    in_bus.operation <= op;
    in_bus.start_req <= s;
    in_bus.length    <= len;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic pause_cycles(int n);
    in_bus.valid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  task automatic send_random_beat();
    int pick;
    int k;
    logic [16:0] len;
    logic [15:0] s;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      len = (pool_now > 0 && $urandom_range(0, 3) != 0) ?
            17'($urandom_range(1, (pool_now < 64) ? pool_now : 64)) :
            17'($urandom_range(0, 65536));
      alloc_lens.push_back(len);
      send_beat(bfia_pkg::OP_ALLOC, 16'($urandom_range(0, 65535)), len);
    end else if (pick < 70 && alloc_lens.size() > 0) begin
      k = $urandom_range(0, alloc_lens.size() - 1);
      len = alloc_lens[k];
      s = 16'($urandom_range(0, (pool_now > 0) ? pool_now - 1 : 0));
      alloc_lens.delete(k);
      send_beat(bfia_pkg::OP_FREE, s,
                ($urandom_range(0, 1) != 0) ? 17'($urandom_range(1, 8)) : len);
    end else if (pick < 85) begin
      s = 16'($urandom_range(0, (pool_now > 0) ? pool_now - 1 : 0));
      send_beat(bfia_pkg::OP_QUERY, s, 17'($urandom_range(0, 40)));
    end else if (pick < 92) begin
      len = 17'(pool_now + $urandom_range(0, 200));
      if ($urandom_range(0, 4) == 0) len = 17'($urandom_range(0, 65536));
      if (len <= 17'h10000 && len >= pool_now) pool_now = len;
      send_beat(bfia_pkg::OP_GROW, 16'($urandom_range(0, 65535)), len);
    end else if (pick < 97) begin
      len = ($urandom_range(0, 5) == 0) ? 17'($urandom_range(0, 131071)) :
            17'($urandom_range(64, 2048));
      if (len <= 17'h10000) begin
        pool_now = len;
        alloc_lens.delete();
      end
      send_beat(bfia_pkg::OP_CLEAR, 16'($urandom_range(0, 65535)), len);
    end else begin
      send_beat(3'($urandom_range(5, 7)), 16'($urandom_range(0, 65535)),
                17'($urandom_range(0, 131071)));
    end
  endtask

  initial begin
    int burst;
    rst_n = 1'b0;
    long_hold = 1'b0;
    pool_now = 0;
    in_bus.valid = 1'b0;
    in_bus.operation = bfia_pkg::OP_ALLOC;
    in_bus.start_req = '0;
    in_bus.length = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_beat(bfia_pkg::OP_ALLOC, 16'd0, 17'd5);
    send_beat(bfia_pkg::OP_QUERY, 16'd0, 17'd1);
    send_beat(bfia_pkg::OP_GROW, 16'd0, 17'd100);
    send_beat(bfia_pkg::OP_GROW, 16'd0, 17'd100);
    send_beat(bfia_pkg::OP_GROW, 16'd0, 17'd50);
    send_beat(bfia_pkg::OP_ALLOC, 16'd0, 17'd0);
    send_beat(bfia_pkg::OP_ALLOC, 16'd0, 17'd30);
    send_beat(bfia_pkg::OP_ALLOC, 16'd0, 17'd20);
    send_beat(bfia_pkg::OP_ALLOC, 16'd0, 17'd200);
    send_beat(bfia_pkg::OP_QUERY, 16'd0, 17'd30);
    send_beat(bfia_pkg::OP_QUERY, 16'd20, 17'd40);
    send_beat(bfia_pkg::OP_QUERY, 16'd60, 17'd40);
    send_beat(bfia_pkg::OP_QUERY, 16'd90, 17'd20);
    send_beat(bfia_pkg::OP_FREE, 16'd40, 17'd5);
    send_beat(bfia_pkg::OP_FREE, 16'd0, 17'd0);
    send_beat(bfia_pkg::OP_FREE, 16'd10, 17'd5);
    send_beat(bfia_pkg::OP_FREE, 16'd0, 17'd10);
    send_beat(bfia_pkg::OP_FREE, 16'd15, 17'd35);
    send_beat(bfia_pkg::OP_CLEAR, 16'hFFFF, 17'h10001);
    send_beat(bfia_pkg::OP_CLEAR, 16'd0, 17'd0);
    send_beat(bfia_pkg::OP_CLEAR, 16'd0, 17'h10000);
    send_beat(bfia_pkg::OP_ALLOC, 16'd0, 17'h10000);
    send_beat(bfia_pkg::OP_QUERY, 16'hFFFF, 17'd1);
    send_beat(3'd7, 16'hFFFF, 17'h1FFFF);
    send_beat(bfia_pkg::OP_CLEAR, 16'd0, 17'd1024);
    pool_now = 1024;

    for (int n = 0; n < 1400; ) begin
      burst = $urandom_range(1, 12);
      for (int b = 0; b < burst; b++) send_random_beat();
      n += burst;
      if ($urandom_range(0, 2) == 0) pause_cycles($urandom_range(1, 150));
      if (n > 400 && n <= 400 + burst) begin
        long_hold = 1'b1;
        fork
          begin
            repeat (1200) @(negedge clk);
            long_hold = 1'b0;
          end
          for (int b = 0; b < 6; b++) send_random_beat();
        join
        n += 6;
      end
      if (n > 900 && n <= 900 + burst) begin
        in_bus.valid <= 1'b0;
        while (pending_count != 0) @(negedge clk);
      end
    end
    in_bus.valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

// File: files.f
rtl/bfia_pkg.sv
rtl/bfia_in_if.sv
rtl/bfia_out_if.sv
rtl/bfia_table.sv
rtl/bfia_scan.sv
rtl/best_fit_interval_allocator.sv
tb/sv/bfia_checker.sv
tb/sv/tb_best_fit_interval_allocator.sv
